@@ design/pps_pkg.sv @@
// Package for the preemptive priority scheduler.
// Holds request codes, time limits and the structs shared by the top level and its cells.
// No dependencies.
package pps_pkg;

    localparam int SLOT_W = 6;
    localparam int TIME_W = 32;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic              clear;
        logic              load;
        logic              serve;
        logic              scan;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        id;
        logic [TIME_W-1:0] arrival;
        logic [15:0]       burst;
        logic [7:0]        prio;
        logic [TIME_W-1:0] now;
    } cell_cmd_t;

    // best candidate so far, handed from cell to cell during a scan
    typedef struct packed {
        logic              found;
        logic [7:0]        prio;
        logic [TIME_W-1:0] arrival;
        logic [7:0]        id;
        logic [15:0]       burst;
        logic [15:0]       remaining;
        logic              started;
        logic [SLOT_W-1:0] slot;
    } cand_t;

endpackage

@@ design/pps_cell.sv @@
// One table slot of the preemptive priority scheduler.
// Holds one process entry and merges it into the candidate passed along the chain.
// Depends on pps_pkg.
module pps_cell #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pps_pkg::cell_cmd_t cmd,
    input  pps_pkg::cand_t    cand_in,
    output pps_pkg::cand_t    cand_out
);

    logic        live_reg;
    logic        live_next;
    logic        started_reg;
    logic        started_next;
    logic [7:0]  id_reg;
    logic [31:0] arrival_reg;
    logic [15:0] burst_reg;
    logic [15:0] remaining_reg;
    logic [15:0] remaining_next;
    logic [7:0]  prio_reg;
    pps_pkg::cand_t cand_reg;
    pps_pkg::cand_t cand_next;
    pps_pkg::cand_t own;

    logic hit;
    logic eligible;
    logic wins;

    assign hit = (cmd.slot == pps_pkg::SLOT_W'(IDX));

    always_comb
    begin
        live_next      = live_reg;
        started_next   = started_reg;
        remaining_next = remaining_reg;
        if (cmd.clear)
        begin
            live_next    = 1'b0;
            started_next = 1'b0;
        end
        else if (cmd.load && hit)
        begin
            live_next      = 1'b1;
            started_next   = 1'b0;
            remaining_next = cmd.burst;
        end
        else if (cmd.serve && hit)
        begin
            started_next   = 1'b1;
            remaining_next = remaining_reg - 16'd1;
            if (remaining_reg == 16'd1)
            begin
                live_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        own.found     = 1'b1;
        own.prio      = prio_reg;
        own.arrival   = arrival_reg;
        own.id        = id_reg;
        own.burst     = burst_reg;
        own.remaining = remaining_reg;
        own.started   = started_reg;
        own.slot      = pps_pkg::SLOT_W'(IDX);

        eligible = live_reg && (arrival_reg <= cmd.now);
        // strict order keeps the earlier slot on a full tie
        if (prio_reg != cand_in.prio)
        begin
            wins = prio_reg < cand_in.prio;
        end
        else if (arrival_reg != cand_in.arrival)
        begin
            wins = arrival_reg < cand_in.arrival;
        end
        else
        begin
            wins = id_reg < cand_in.id;
        end

        cand_next = cand_reg;
        if (cmd.scan)
        begin
            if (eligible && (!cand_in.found || wins))
            begin
                cand_next = own;
            end
            else
            begin
                cand_next = cand_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg    <= 1'b0;
            started_reg <= 1'b0;
            cand_reg    <= '0;
        end
        else
        begin
            live_reg    <= live_next;
            started_reg <= started_next;
            cand_reg    <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        remaining_reg <= remaining_next;
        if (cmd.load && hit && !cmd.clear)
        begin
            id_reg      <= cmd.id;
            arrival_reg <= cmd.arrival;
            burst_reg   <= cmd.burst;
            prio_reg    <= cmd.prio;
        end
    end

    assign cand_out = cand_reg;

endmodule

@@ design/preemptive_priority_scheduler.sv @@
// A clear or load request is taken in IDLE and gives no response. A tick steps through the
// states in order: acceptance in IDLE, SCAN while the best candidate ripples down the chain
// of slot cells, TAT for the turnaround subtraction, and EMIT to register the response, where
// it waits only while rsp_stall is high. No new request is taken during a tick.
// Top level: request sequencer, time and count state, response register.
// Depends on pps_pkg and pps_cell.
module preemptive_priority_scheduler #(
    parameter int MAX_PROCS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  proc_id,
    input  logic [31:0] arrival_time,
    input  logic [15:0] burst_length,
    input  logic [7:0]  priority_level,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic        run_valid,
    output logic [7:0]  run_id,
    output logic        segment_start,
    output logic        first_dispatch,
    output logic        finished,
    output logic [31:0] tick_time,
    output logic [31:0] finish_time,
    output logic [31:0] turnaround,
    output logic [31:0] waiting,
    output logic        all_done
);

    localparam int CNT_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int LC_W  = $clog2(MAX_PROCS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_TAT  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] scan_cnt_reg;
    logic [CNT_W-1:0] scan_cnt_next;
    logic [31:0]      cur_time_reg;
    logic [31:0]      cur_time_next;
    logic [31:0]      fin_reg;
    logic [31:0]      tat_reg;
    logic [7:0]       last_id_reg;
    logic [7:0]       last_id_next;
    logic             has_run_reg;
    logic             has_run_next;
    logic [LC_W-1:0]  loaded_cnt_reg;
    logic [LC_W-1:0]  loaded_cnt_next;
    logic [LC_W-1:0]  unf_cnt_reg;
    logic [LC_W-1:0]  unf_cnt_next;

    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    logic        run_valid_reg;
    logic [7:0]  run_id_reg;
    logic        seg_start_reg;
    logic        first_disp_reg;
    logic        finished_reg;
    logic [31:0] tick_time_reg;
    logic [31:0] finish_time_reg;
    logic [31:0] turnaround_reg;
    logic [31:0] waiting_reg;
    logic        all_done_reg;

    logic accept;
    logic clear_fire;
    logic load_fire;
    logic emit_fire;
    logic done_now;
    logic [LC_W-1:0] unf_after;

    pps_pkg::cell_cmd_t cmd;
    pps_pkg::cand_t     chain [MAX_PROCS+1];
    pps_pkg::cand_t     best;

    assign req_stall  = (state_reg != ST_IDLE);
    assign accept     = req_valid && !req_stall;
    assign clear_fire = accept && (req_type == pps_pkg::REQ_CLEAR);
    assign load_fire  = accept && (req_type == pps_pkg::REQ_LOAD)
                        && (loaded_cnt_reg < LC_W'(MAX_PROCS)) && (burst_length != 16'd0);
    assign emit_fire  = (state_reg == ST_EMIT) && (!rsp_valid_reg || !rsp_stall);
    assign best       = chain[MAX_PROCS];
    assign done_now   = best.found && (best.remaining == 16'd1);
    assign unf_after  = (done_now && (unf_cnt_reg != '0)) ? unf_cnt_reg - LC_W'(1) : unf_cnt_reg;

    always_comb
    begin
        cmd.clear   = clear_fire;
        cmd.load    = load_fire;
        cmd.serve   = emit_fire && best.found;
        cmd.scan    = (state_reg == ST_SCAN);
        cmd.slot    = cmd.serve ? best.slot : pps_pkg::SLOT_W'(loaded_cnt_reg);
        cmd.id      = proc_id;
        cmd.arrival = arrival_time;
        cmd.burst   = burst_length;
        cmd.prio    = priority_level;
        cmd.now     = cur_time_reg;
    end

    assign chain[0] = '0;

    for (genvar g = 0; g < MAX_PROCS; g++)
    begin : g_cell
        pps_cell #(
            .IDX(g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .cand_in  (chain[g]),
            .cand_out (chain[g+1])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        scan_cnt_next   = scan_cnt_reg;
        cur_time_next   = cur_time_reg;
        last_id_next    = last_id_reg;
        has_run_next    = has_run_reg;
        loaded_cnt_next = loaded_cnt_reg;
        unf_cnt_next    = unf_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (clear_fire)
                begin
                    cur_time_next   = '0;
                    last_id_next    = '0;
                    has_run_next    = 1'b0;
                    loaded_cnt_next = '0;
                    unf_cnt_next    = '0;
                end
                else if (load_fire)
                begin
                    loaded_cnt_next = loaded_cnt_reg + LC_W'(1);
                    unf_cnt_next    = unf_cnt_reg + LC_W'(1);
                end
                else if (accept && (req_type == pps_pkg::REQ_TICK))
                begin
                    scan_cnt_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                if (scan_cnt_reg == CNT_W'(MAX_PROCS - 1))
                begin
                    state_next = ST_TAT;
                end
            end
            ST_TAT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    cur_time_next = fin_reg;
                    unf_cnt_next  = unf_after;
                    if (best.found)
                    begin
                        has_run_next = 1'b1;
                        last_id_next = best.id;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_cnt_reg   <= '0;
            cur_time_reg   <= '0;
            last_id_reg    <= '0;
            has_run_reg    <= 1'b0;
            loaded_cnt_reg <= '0;
            unf_cnt_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            cur_time_reg   <= cur_time_next;
            last_id_reg    <= last_id_next;
            has_run_reg    <= has_run_next;
            loaded_cnt_reg <= loaded_cnt_next;
            unf_cnt_reg    <= unf_cnt_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (emit_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // saturating finish time is registered during the scan, turnaround in the following TAT state
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN)
        begin
            fin_reg <= (cur_time_reg == pps_pkg::TIME_MAX) ? pps_pkg::TIME_MAX
                                                           : cur_time_reg + 32'd1;
        end
        if (state_reg == ST_TAT)
        begin
            tat_reg <= fin_reg - best.arrival;
        end
        if (emit_fire)
        begin
            run_valid_reg  <= best.found;
            run_id_reg     <= best.found ? best.id : 8'd0;
            seg_start_reg  <= best.found && (!has_run_reg || (last_id_reg != best.id));
            first_disp_reg <= best.found && !best.started;
            finished_reg   <= done_now;
            tick_time_reg  <= cur_time_reg;
            all_done_reg   <= (unf_after == '0);
            if (done_now)
            begin
                finish_time_reg <= fin_reg;
                turnaround_reg  <= tat_reg;
                waiting_reg     <= (tat_reg >= {16'd0, best.burst})
                                   ? tat_reg - {16'd0, best.burst} : 32'd0;
            end
            else
            begin
                finish_time_reg <= '0;
                turnaround_reg  <= '0;
                waiting_reg     <= '0;
            end
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign run_valid      = run_valid_reg;
    assign run_id         = run_id_reg;
    assign segment_start  = seg_start_reg;
    assign first_dispatch = first_disp_reg;
    assign finished       = finished_reg;
    assign tick_time      = tick_time_reg;
    assign finish_time    = finish_time_reg;
    assign turnaround     = turnaround_reg;
    assign waiting        = waiting_reg;
    assign all_done       = all_done_reg;

    a_unf_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        unf_cnt_reg <= loaded_cnt_reg)
        else $error("unfinished count exceeds loaded count");

    a_best_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && best.found) |-> (best.remaining != 16'd0))
        else $error("selected entry has no remaining service");

    a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !clear_fire |=> (cur_time_reg >= $past(cur_time_reg)))
        else $error("time moved backward without a clear");

    a_rsp_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("response raised outside the emit state");

endmodule
